// ===== rtl/grid_dijkstra_path_search_assert.svh =====
// Assertion macros for the grid path search block.
// Used by the search engine; compiled out when SYNTHESIS is defined.
`ifndef GRID_DIJKSTRA_PATH_SEARCH_ASSERT_SVH
`define GRID_DIJKSTRA_PATH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define GDPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GDPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GDPS_ASSERT_IMP(lbl, ante, cons, msg)
`define GDPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/gdps_pkg.sv =====
// Shared types, codes and constants of the grid path search block.
// No dependencies.
package gdps_pkg;

  localparam int unsigned MAX_CELLS_DEF = 4096;

  localparam logic [15:0] DIST_INF  = 16'hFFFF;
  localparam logic [15:0] DIST_SAT  = 16'hFFFE;
  localparam logic [12:0] LINK_NONE = 13'h1FFF;

  localparam logic [3:0] PLAIN_COST  = 4'd1;
  localparam logic [3:0] WEIGHT_COST = 4'd10;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;
  localparam logic [1:0] REG_END   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] cell_index;
    logic        is_wall;
    logic        is_weighted;
  } gdps_in_t;

  typedef struct packed {
    logic        search_done;
    logic        found;
    logic [15:0] end_distance;
    logic [12:0] path_length;
    logic [11:0] path_cell;
    logic        out_of_range;
  } gdps_out_t;

  typedef struct packed {
    logic [6:0]  grid_cols;
    logic [6:0]  grid_rows;
    logic [11:0] start_cell;
    logic [11:0] end_cell;
  } gdps_cfg_t;

  typedef struct packed {
    logic [11:0] node;
    logic [15:0] key;
  } gdps_heap_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_WRITE, ST_READ, ST_CLEAR, ST_START, ST_LOOP,
    ST_EX_ROOT, ST_EX_LAST, ST_SD_CHK, ST_SD_L, ST_SD_R, ST_DIV, ST_NB,
    ST_NB_W, ST_SU_CHK, ST_SU_W, ST_NEXT_K, ST_FIN, ST_FIN_W, ST_PATH,
    ST_PATH_W, ST_DONE
  } gdps_state_t;

endpackage

// ===== rtl/gdps_engine.sv =====
// Search engine: grid maps, distance/parent/slot tables, binary heap, path store
// and the sequencer that walks them. Depends on gdps_pkg and the assert header.
`include "grid_dijkstra_path_search_assert.svh"

module gdps_engine import gdps_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  gdps_in_t  cmd,
  input  gdps_cfg_t cfg,
  output logic      idle,
  output logic      res_valid,
  output gdps_out_t res,
  input  logic      res_ack
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = AW + 1;
  localparam int PW = AW + 2;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CELLS);

  // memories
  logic [1:0]  map_mem  [MAX_CELLS];
  logic [15:0] dist_mem [MAX_CELLS];
  logic [12:0] par_mem  [MAX_CELLS];
  logic [CW-1:0] slot_mem [MAX_CELLS];
  gdps_heap_t  heap_mem [MAX_CELLS];
  logic [11:0] path_mem [MAX_CELLS];

  logic          map_we, dp_we, slot_we, heap_we, path_we;
  logic [AW-1:0] map_wa, dp_wa, slot_wa, heap_wa, path_wa, cell_ra, heap_ra, path_ra;
  logic [1:0]    map_wd, map_q;
  logic [15:0]   dist_wd, dist_q;
  logic [12:0]   par_wd, par_q;
  logic [CW-1:0] slot_wd, slot_q;
  gdps_heap_t    heap_wd, heap_q;
  logic [11:0]   path_wd, path_q;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (dp_we) begin
      dist_mem[dp_wa] <= dist_wd;
      par_mem[dp_wa]  <= par_wd;
    end
    dist_q <= dist_mem[cell_ra];
    par_q  <= par_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_q <= slot_mem[cell_ra];
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_q <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_q <= path_mem[path_ra];
  end

  // sequencer registers
  gdps_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic          found_r, found_nxt;
  logic          solved_r, solved_nxt;
  logic [15:0]   goal_r, goal_nxt;
  gdps_in_t      cmd_r, cmd_nxt;
  gdps_heap_t    cur_r, cur_nxt;
  gdps_heap_t    item_r, item_nxt;
  gdps_heap_t    lch_r, lch_nxt;
  logic          pickl_r, pickl_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [11:0]   shift_r, shift_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic [3:0]    div_r, div_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [11:0]   nb_r, nb_nxt;
  logic [11:0]   c_r, c_nxt;

  // derived values
  logic [13:0] total;
  logic        geom_bad, init_last, clr_last;
  logic [PW-1:0] l_pos, r_pos;
  logic          l_in, r_in;
  logic [AW-1:0] par_pos;
  logic [7:0]    div_t;
  logic          nb_ok;
  logic [11:0]   nb_cell;
  logic [16:0]   nd_sum;
  logic [15:0]   nd;
  logic          improve, rd_in, r_better;
  logic [15:0]   ref_dist;

  assign total     = 14'(cfg.grid_cols) * 14'(cfg.grid_rows);
  assign geom_bad  = (cfg.grid_cols == '0) || (cfg.grid_rows == '0) ||
                     (32'(total) > 32'(MAX_CELLS)) || (14'(cfg.start_cell) >= total);
  assign init_last = (cnt_r == CW'(MAX_CELLS - 1));
  assign clr_last  = init_last;
  assign l_pos     = (PW'(pos_r) << 1) + PW'(1);
  assign r_pos     = l_pos + PW'(1);
  assign l_in      = l_pos < PW'(hcnt_r);
  assign r_in      = r_pos < PW'(hcnt_r);
  assign par_pos   = AW'((pos_r - AW'(1)) >> 1);
  assign div_t     = {rem_r, shift_r[11]};
  assign ref_dist  = pickl_r ? lch_r.key : item_r.key;
  assign r_better  = heap_q.key < ref_dist;

  // neighbor k of the current cell: up, left, down, right
  always_comb begin
    nb_ok   = 1'b0;
    nb_cell = cur_r.node;
    case (k_r)
      2'd0: begin
        nb_ok   = cur_r.node >= 12'(cfg.grid_cols);
        nb_cell = cur_r.node - 12'(cfg.grid_cols);
      end
      2'd1: begin
        nb_ok   = rem_r != '0;
        nb_cell = cur_r.node - 12'd1;
      end
      2'd2: begin
        nb_ok   = (14'(cur_r.node) + 14'(cfg.grid_cols)) < total;
        nb_cell = cur_r.node + 12'(cfg.grid_cols);
      end
      default: begin
        nb_ok   = (8'(rem_r) + 8'd1) < 8'(cfg.grid_cols);
        nb_cell = cur_r.node + 12'd1;
      end
    endcase
    nb_ok = nb_ok && (14'(nb_cell) < total);
  end

  assign nd_sum  = 17'(cur_r.key) + 17'(map_q[0] ? WEIGHT_COST : PLAIN_COST);
  assign nd      = (nd_sum > 17'(DIST_SAT)) ? DIST_SAT : nd_sum[15:0];
  assign improve = !map_q[1] && (nd < dist_q);
  assign rd_in   = (CW'(cmd_r.cell_index) < pcnt_r) &&
                   (32'(cmd_r.cell_index) < 32'(MAX_CELLS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:    if (init_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (go) begin
          case (cmd.op)
            OP_RUN:  state_nxt = ST_CLEAR;
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_WRITE;
          endcase
        end
      end
      ST_WRITE:   state_nxt = ST_DONE;
      ST_READ:    state_nxt = ST_DONE;
      ST_CLEAR:   if (clr_last) state_nxt = geom_bad ? ST_FIN : ST_START;
      ST_START:   state_nxt = ST_LOOP;
      ST_LOOP:    state_nxt = (hcnt_r == '0 || solved_r) ? ST_FIN : ST_EX_ROOT;
      ST_EX_ROOT: state_nxt = (hcnt_r != CW'(1)) ? ST_EX_LAST : ST_DIV;
      ST_EX_LAST: state_nxt = ST_SD_CHK;
      ST_SD_CHK:  state_nxt = l_in ? ST_SD_L : ST_DIV;
      ST_SD_L: begin
        if (r_in) state_nxt = ST_SD_R;
        else if (heap_q.key < item_r.key) state_nxt = ST_SD_CHK;
        else state_nxt = ST_DIV;
      end
      ST_SD_R:    state_nxt = (r_better || pickl_r) ? ST_SD_CHK : ST_DIV;
      ST_DIV:     if (div_r == 4'd11) state_nxt = ST_NB;
      ST_NB:      state_nxt = nb_ok ? ST_NB_W : ST_NEXT_K;
      ST_NB_W: begin
        if (improve && (slot_q != '0 || hcnt_r < CNT_MAX)) state_nxt = ST_SU_CHK;
        else state_nxt = ST_NEXT_K;
      end
      ST_SU_CHK:  state_nxt = (pos_r == '0) ? ST_NEXT_K : ST_SU_W;
      ST_SU_W:    state_nxt = (heap_q.key > item_r.key) ? ST_SU_CHK : ST_NEXT_K;
      ST_NEXT_K: begin
        if (solved_r) state_nxt = ST_FIN;
        else if (k_r == 2'd3) state_nxt = ST_LOOP;
        else state_nxt = ST_NB;
      end
      ST_FIN:     state_nxt = ST_FIN_W;
      ST_FIN_W:   state_nxt = solved_r ? ST_PATH : ST_DONE;
      ST_PATH:    state_nxt = ST_PATH_W;
      ST_PATH_W: begin
        if (par_q == LINK_NONE || pcnt_r >= CNT_MAX) state_nxt = ST_DONE;
        else state_nxt = ST_PATH;
      end
      ST_DONE:    if (res_ack) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_nxt    = cnt_r;
    hcnt_nxt   = hcnt_r;
    pcnt_nxt   = pcnt_r;
    found_nxt  = found_r;
    solved_nxt = solved_r;
    goal_nxt   = goal_r;
    cmd_nxt    = cmd_r;
    cur_nxt    = cur_r;
    item_nxt   = item_r;
    lch_nxt    = lch_r;
    pickl_nxt  = pickl_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    k_nxt      = k_r;
    nb_nxt     = nb_r;
    c_nxt      = c_r;
    map_we  = 1'b0; map_wa  = AW'(cmd_r.cell_index);
    map_wd  = {cmd_r.is_wall, cmd_r.is_weighted};
    dp_we   = 1'b0; dp_wa   = AW'(cnt_r); dist_wd = DIST_INF; par_wd = LINK_NONE;
    slot_we = 1'b0; slot_wa = AW'(cnt_r); slot_wd = '0;
    heap_we = 1'b0; heap_wa = pos_r; heap_wd = item_r;
    path_we = 1'b0; path_wa = AW'(pcnt_r); path_wd = c_r;
    cell_ra = AW'(nb_cell);
    heap_ra = '0;
    path_ra = AW'(cmd_r.cell_index);
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_INIT: begin
        map_we  = 1'b1; map_wa = AW'(cnt_r); map_wd = '0;
        dp_we   = 1'b1;
        slot_we = 1'b1;
        cnt_nxt = init_last ? '0 : cnt_r + CW'(1);
      end
      ST_IDLE: begin
        idle = 1'b1;
        if (go) begin
          cmd_nxt = cmd;
          if (cmd.op == OP_RUN) begin
            found_nxt  = 1'b0;
            solved_nxt = 1'b0;
            goal_nxt   = DIST_INF;
            pcnt_nxt   = '0;
            hcnt_nxt   = '0;
            cnt_nxt    = '0;
          end
        end
      end
      // the unused op lands here too and leaves the maps alone
      ST_WRITE: map_we = (cmd_r.op == OP_WRITE) &&
                         (32'(cmd_r.cell_index) < 32'(MAX_CELLS));
      ST_CLEAR: begin
        dp_we   = 1'b1;
        slot_we = 1'b1;
        cnt_nxt = clr_last ? '0 : cnt_r + CW'(1);
      end
      ST_START: begin
        dp_we   = 1'b1; dp_wa = AW'(cfg.start_cell); dist_wd = '0;
        heap_we = 1'b1; heap_wa = '0; heap_wd = '{node: cfg.start_cell, key: '0};
        slot_we = 1'b1; slot_wa = AW'(cfg.start_cell); slot_wd = CW'(1);
        hcnt_nxt = CW'(1);
      end
      ST_LOOP: heap_ra = '0;
      ST_EX_ROOT: begin
        cur_nxt   = heap_q;
        slot_we   = 1'b1; slot_wa = AW'(heap_q.node); slot_wd = '0;
        hcnt_nxt  = hcnt_r - CW'(1);
        heap_ra   = AW'(hcnt_r - CW'(1));
        shift_nxt = heap_q.node;
        rem_nxt   = '0;
        div_nxt   = '0;
        k_nxt     = '0;
      end
      ST_EX_LAST: begin
        item_nxt = heap_q;
        pos_nxt  = '0;
      end
      ST_SD_CHK: begin
        heap_ra = AW'(l_pos);
        if (!l_in) begin
          heap_we = 1'b1;
          slot_we = 1'b1; slot_wa = AW'(item_r.node); slot_wd = CW'(pos_r) + CW'(1);
        end
      end
      ST_SD_L: begin
        lch_nxt   = heap_q;
        pickl_nxt = heap_q.key < item_r.key;
        heap_ra   = AW'(r_pos);
        if (!r_in) begin
          heap_we = 1'b1;
          slot_we = 1'b1; slot_wd = CW'(pos_r) + CW'(1);
          if (heap_q.key < item_r.key) begin
            heap_wd = heap_q; slot_wa = AW'(heap_q.node); pos_nxt = AW'(l_pos);
          end else begin
            slot_wa = AW'(item_r.node);
          end
        end
      end
      ST_SD_R: begin
        heap_we = 1'b1;
        slot_we = 1'b1; slot_wd = CW'(pos_r) + CW'(1);
        if (r_better) begin
          heap_wd = heap_q; slot_wa = AW'(heap_q.node); pos_nxt = AW'(r_pos);
        end else if (pickl_r) begin
          heap_wd = lch_r; slot_wa = AW'(lch_r.node); pos_nxt = AW'(l_pos);
        end else begin
          slot_wa = AW'(item_r.node);
        end
      end
      ST_DIV: begin
        // restoring remainder, one quotient bit per cycle
        rem_nxt   = (div_t >= {1'b0, cfg.grid_cols}) ? 7'(div_t - {1'b0, cfg.grid_cols})
                                                     : div_t[6:0];
        shift_nxt = shift_r << 1;
        div_nxt   = div_r + 4'd1;
      end
      ST_NB: nb_nxt = nb_cell;
      ST_NB_W: begin
        if (improve) begin
          dp_we      = 1'b1; dp_wa = AW'(nb_r); dist_wd = nd; par_wd = {1'b0, cur_r.node};
          item_nxt   = '{node: nb_r, key: nd};
          solved_nxt = nb_r == cfg.end_cell;
          if (slot_q != '0) begin
            pos_nxt = AW'(slot_q - CW'(1));
          end else if (hcnt_r < CNT_MAX) begin
            pos_nxt  = AW'(hcnt_r);
            hcnt_nxt = hcnt_r + CW'(1);
          end
        end
      end
      ST_SU_CHK: begin
        heap_ra = par_pos;
        if (pos_r == '0) begin
          heap_we = 1'b1;
          slot_we = 1'b1; slot_wa = AW'(item_r.node); slot_wd = CW'(1);
        end
      end
      ST_SU_W: begin
        heap_we = 1'b1;
        slot_we = 1'b1; slot_wd = CW'(pos_r) + CW'(1);
        if (heap_q.key > item_r.key) begin
          heap_wd = heap_q; slot_wa = AW'(heap_q.node); pos_nxt = par_pos;
        end else begin
          slot_wa = AW'(item_r.node);
        end
      end
      ST_NEXT_K: k_nxt = k_r + 2'd1;
      ST_FIN: cell_ra = AW'(cfg.end_cell);
      ST_FIN_W: begin
        goal_nxt = (32'(cfg.end_cell) < 32'(MAX_CELLS)) ? dist_q : DIST_INF;
        if (solved_r) begin
          found_nxt = 1'b1;
          path_we   = 1'b1; path_wa = '0; path_wd = cfg.end_cell;
          pcnt_nxt  = CW'(1);
          c_nxt     = cfg.end_cell;
        end
      end
      ST_PATH: cell_ra = AW'(c_r);
      ST_PATH_W: begin
        if (par_q != LINK_NONE && pcnt_r < CNT_MAX) begin
          c_nxt    = par_q[11:0];
          path_we  = 1'b1; path_wd = par_q[11:0];
          pcnt_nxt = pcnt_r + CW'(1);
        end
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.search_done  = cmd_r.op == OP_RUN;
    res.found        = found_r;
    res.end_distance = goal_r;
    res.path_length  = 13'(pcnt_r);
    res.path_cell    = (cmd_r.op == OP_READ && rd_in) ? path_q : '0;
    res.out_of_range = (cmd_r.op == OP_READ) && !rd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cnt_r    <= '0;
      hcnt_r   <= '0;
      pcnt_r   <= '0;
      found_r  <= 1'b0;
      solved_r <= 1'b0;
      goal_r   <= DIST_INF;
      cmd_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      hcnt_r   <= hcnt_nxt;
      pcnt_r   <= pcnt_nxt;
      found_r  <= found_nxt;
      solved_r <= solved_nxt;
      goal_r   <= goal_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    item_r  <= item_nxt;
    lch_r   <= lch_nxt;
    pickl_r <= pickl_nxt;
    pos_r   <= pos_nxt;
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    k_r     <= k_nxt;
    nb_r    <= nb_nxt;
    c_r     <= c_nxt;
  end

  `GDPS_ASSERT_IMP(a_heap_bound, 1'b1, hcnt_r <= CNT_MAX, "heap count above capacity")
  `GDPS_ASSERT_IMP(a_found_path, res_valid && res.found, pcnt_r != '0, "found with empty path")
  `GDPS_ASSERT_NXT(a_go_busy, go && idle, !idle, "engine idle after a command")

endmodule

// ===== rtl/grid_dijkstra_path_search.sv =====
// Top level of the grid path search block: configuration registers, input
// handshake and result register around gdps_engine. Depends on gdps_pkg and gdps_engine.
//
// Usage:
//  - cfg_*: write channel for grid_cols, grid_rows, start_cell, end_cell
//    (index 0..3). cfg_ready is always high; write only while idle.
//  - in_*: one item per transfer (in_valid high, in_stall low). op selects
//    cell write, search run or path read.
//  - out_*: exactly one result per item, held until a transfer completes
//    (out_valid high, out_stall low).
// Sequence: a cell write or a path read passes ST_WRITE or ST_READ, then offers
// its result. A run first sweeps MAX_CELLS entries of the distance/parent/slot
// tables, then extracts cells from the heap; each extraction sifts the heap
// down by level and works out the column remainder of the cell, and each
// improved neighbor may be sifted up by level. Path readout follows the parent
// links cell by cell. One item is worked at a time: in_stall stays high from
// transfer until the engine has handed its result to the output register.
// Reset: rst_n is synchronous, active low. Afterwards the wall/weight map is
// swept to zero over all MAX_CELLS entries with in_stall high.
// A stalled output keeps its result; the engine holds the next result until
// the output register frees, while still accepting no new item.

module grid_dijkstra_path_search import gdps_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  gdps_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output gdps_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data
);

  gdps_cfg_t cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  gdps_out_t out_data_r, out_data_nxt;
  logic      eng_idle, eng_res_valid, res_ack, in_xfer;
  gdps_out_t eng_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = !eng_idle;
  assign in_xfer   = in_valid && !in_stall;
  // result moves into the output register when it is empty or draining
  assign res_ack   = eng_res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_COLS:  cfg_nxt.grid_cols  = cfg_data[6:0];
        REG_ROWS:  cfg_nxt.grid_rows  = cfg_data[6:0];
        REG_START: cfg_nxt.start_cell = cfg_data;
        REG_END:   cfg_nxt.end_cell   = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (res_ack) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = eng_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{grid_cols: 7'd64, grid_rows: 7'd64, start_cell: '0, end_cell: '0};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gdps_engine #(
    .MAX_CELLS(MAX_CELLS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (in_xfer),
    .cmd      (in_data),
    .cfg      (cfg_r),
    .idle     (eng_idle),
    .res_valid(eng_res_valid),
    .res      (eng_res),
    .res_ack  (res_ack)
  );

endmodule

// ===== sim/gdps_checker.sv =====
// Checker for the grid path search block: watches the item, result and register
// channels, predicts every result and compares it field by field. Uses gdps_pkg.
module gdps_checker import gdps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  gdps_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  gdps_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count
);

  localparam int unsigned NCELL = MAX_CELLS_DEF;

  bit          wall_m [NCELL];
  bit          heavy_m[NCELL];
  bit [15:0]   dist_m [NCELL];
  bit [12:0]   link_m [NCELL];
  int unsigned hcell[NCELL], hdist[NCELL], hpos[NCELL], hcnt;
  bit [11:0]   route[NCELL];
  int unsigned route_len;
  bit          found_m;
  bit [15:0]   goal_m;
  bit [6:0]    cols_m, rows_m;
  bit [11:0]   start_m, end_m;

  gdps_out_t   expected_q[$];
  int          mism;

  function void hswap(int unsigned a, int unsigned b);
    int unsigned tc, td;
    tc = hcell[a]; td = hdist[a];
    hcell[a] = hcell[b]; hdist[a] = hdist[b];
    hcell[b] = tc; hdist[b] = td;
    hpos[hcell[a]] = a + 1;
    hpos[hcell[b]] = b + 1;
  endfunction

  function void heap_up(int unsigned i);
    while (i != 0 && hdist[(i - 1) / 2] > hdist[i]) begin
      hswap(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  // ties keep the parent; left child wins a tie against the right
  function void heap_down(int unsigned i);
    int unsigned l, r, m;
    while (1) begin
      l = 2 * i + 1; r = 2 * i + 2; m = i;
      if (l < hcnt && hdist[l] < hdist[m]) m = l;
      if (r < hcnt && hdist[r] < hdist[m]) m = r;
      if (m == i) return;
      hswap(i, m);
      i = m;
    end
  endfunction

  function void heap_push(int unsigned c, int unsigned d);
    if (hcnt >= NCELL) return;
    hcell[hcnt] = c; hdist[hcnt] = d;
    hpos[c] = hcnt + 1;
    hcnt++;
    heap_up(hcnt - 1);
  endfunction

  function void search_grid();
    int unsigned total, cols, rows, cur, cd, x, y, n, nd, p, c;
    bit solved, ok;
    cols = cols_m; rows = rows_m;
    total = cols * rows;
    solved = 0;
    found_m = 0; goal_m = DIST_INF; route_len = 0; hcnt = 0;
    for (int i = 0; i < NCELL; i++) begin
      dist_m[i] = DIST_INF; link_m[i] = LINK_NONE; hpos[i] = 0;
    end
    if (cols == 0 || rows == 0 || total > NCELL || start_m >= total) return;
    dist_m[start_m] = '0;
    heap_push(start_m, 0);
    while (hcnt > 0 && !solved) begin
      cur = hcell[0]; cd = hdist[0];
      hpos[cur] = 0;
      hcnt--;
      if (hcnt > 0) begin
        hcell[0] = hcell[hcnt]; hdist[0] = hdist[hcnt];
        hpos[hcell[0]] = 1;
        heap_down(0);
      end
      x = cur % cols; y = cur / cols;
      // up, left, down, right
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin ok = y > 0;        n = cur - cols; end
          1: begin ok = x > 0;        n = cur - 1;    end
          2: begin ok = y + 1 < rows; n = cur + cols; end
          default: begin ok = x + 1 < cols; n = cur + 1; end
        endcase
        if (!ok || n >= total || wall_m[n]) continue;
        nd = cd + (heavy_m[n] ? WEIGHT_COST : PLAIN_COST);
        if (nd > DIST_SAT) nd = DIST_SAT;
        if (nd < dist_m[n]) begin
          dist_m[n] = 16'(nd);
          link_m[n] = 13'(cur);
          if (hpos[n] != 0) begin
            p = hpos[n] - 1;
            hdist[p] = nd;
            heap_up(p);
          end else begin
            heap_push(n, nd);
          end
          if (n == end_m) begin
            solved = 1;
            break;
          end
        end
      end
    end
    goal_m = dist_m[end_m];
    if (solved) begin
      c = end_m;
      found_m = 1;
      route[0] = 12'(c);
      route_len = 1;
      while (link_m[c] != LINK_NONE && route_len < NCELL) begin
        c = link_m[c];
        if (c >= NCELL) break;
        route[route_len++] = 12'(c);
      end
    end
  endfunction

  function gdps_out_t predict_item(gdps_in_t it);
    gdps_out_t r;
    r = '0;
    case (it.op)
      OP_WRITE: begin
        wall_m[it.cell_index]  = it.is_wall;
        heavy_m[it.cell_index] = it.is_weighted;
      end
      OP_RUN: begin
        search_grid();
        r.search_done = 1'b1;
      end
      OP_READ: begin
        if (it.cell_index < route_len) r.path_cell = route[it.cell_index];
        else r.out_of_range = 1'b1;
      end
      default: ;
    endcase
    r.found        = found_m;
    r.end_distance = goal_m;
    r.path_length  = 13'(route_len);
    return r;
  endfunction

  function void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mism++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    gdps_out_t e;
    if (!rst_n) begin
      cols_m = 7'd64; rows_m = 7'd64; start_m = '0; end_m = '0;
      for (int i = 0; i < NCELL; i++) begin
        wall_m[i] = 0; heavy_m[i] = 0;
      end
      route_len = 0; found_m = 0; goal_m = DIST_INF; hcnt = 0;
      expected_q.delete();
      mism = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLS:  cols_m  = cfg_data[6:0];
          REG_ROWS:  rows_m  = cfg_data[6:0];
          REG_START: start_m = cfg_data;
          default:   end_m   = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_item(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mism++;
          $display("%0t: unexpected result 0x%0h", $time, out_data);
        end else begin
          e = expected_q.pop_front();
          check_field("search_done",  e.search_done,  out_data.search_done);
          check_field("found",        e.found,        out_data.found);
          check_field("end_distance", e.end_distance, out_data.end_distance);
          check_field("path_length",  e.path_length,  out_data.path_length);
          check_field("path_cell",    e.path_cell,    out_data.path_cell);
          check_field("out_of_range", e.out_of_range, out_data.out_of_range);
        end
      end
    end
    fail_count <= mism + expected_q.size();
  end

endmodule

// ===== sim/tb_grid_dijkstra_path_search.sv =====
// Testbench top for grid_dijkstra_path_search: clock, reset, stimulus and verdict.
// Depends on gdps_pkg, the block itself and gdps_checker.
module tb_grid_dijkstra_path_search;
  import gdps_pkg::*;

  // idle cycles with no transfer before giving up; sized to outlast a full-size
  // search with a far goal
  localparam int WATCHDOG_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  gdps_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  gdps_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  int          fail_count;

  int sent, rcvd, quiet;
  bit calm;  // no idling on either side while set

  grid_dijkstra_path_search dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gdps_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 23);
  end

  // count result transfers; watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) rcvd++;
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("grid_dijkstra_path_search verification failed");
        $finish;
      end
    end
  end

  // one item transfer; valid stays up between back-to-back items
  task automatic send_item(logic [1:0] op, int unsigned idx, bit wall, bit heavy);
    while (!calm && $urandom_range(99) < 23) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{op: op, cell_index: idx[11:0], is_wall: wall, is_weighted: heavy};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // drain, let the engine settle, then one register transfer
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (rcvd != sent) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[11:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(int unsigned cols, int unsigned rows, int unsigned s, int unsigned e);
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
  endtask

  // grid size pick: mostly small, now and then an odd or extreme value
  function automatic int unsigned pick_dim(bit odd_ok);
    if (odd_ok && $urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: return 0;
        1: return 127;
        default: return 64;
      endcase
    end
    return $urandom_range(1, 8);
  endfunction

  // one random phase: fresh registers, then write/run/read sequences and noise
  task automatic random_phase(int n_items);
    int unsigned cols, rows, total, s, e, hi, cnt, nw, nr;
    cols = pick_dim(1);
    rows = (cols > 8) ? $urandom_range(1, 8) : pick_dim(1);
    total = cols * rows;
    hi = (total == 0) ? 0 : ((total > 4096) ? 4095 : total - 1);
    s = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(hi);
    e = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(hi);
    set_grid(cols, rows, s, e);
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(99) < 8) begin
        // noise: unused op, far write, far read
        case ($urandom_range(2))
          0: send_item(2'd3, $urandom_range(4095), $urandom_range(1), $urandom_range(1));
          1: send_item(OP_WRITE, $urandom_range(4095), $urandom_range(1), $urandom_range(1));
          default: send_item(OP_READ, $urandom_range(4095), $urandom_range(1),
                             $urandom_range(1));
        endcase
        cnt++;
      end else begin
        nw = $urandom_range(2, 8);
        repeat (nw) begin
          send_item(OP_WRITE, $urandom_range(hi), $urandom_range(99) < 25,
                    $urandom_range(99) < 30);
        end
        send_item(OP_RUN, $urandom_range(4095), $urandom_range(1), $urandom_range(1));
        nr = $urandom_range(0, 6);
        for (int p = 0; p <= nr; p++)
          send_item(OP_READ, p, $urandom_range(1), $urandom_range(1));
        send_item(OP_READ, $urandom_range(20), $urandom_range(1), $urandom_range(1));
        cnt += nw + nr + 3;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    sent = 0; calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: 3x3 grid from corner to corner
    set_grid(3, 3, 0, 8);
    send_item(OP_WRITE, 4095, 1, 1);
    send_item(OP_WRITE, 4095, 0, 0);
    send_item(2'd3, 4095, 1, 1);              // unused op
    send_item(OP_READ, 0, 0, 0);              // no path yet
    send_item(OP_WRITE, 4, 1, 0);             // wall in the middle
    send_item(OP_WRITE, 1, 0, 1);             // weighted cell
    send_item(OP_RUN, 0, 0, 0);
    for (int p = 0; p < 6; p++) send_item(OP_READ, p, 0, 0);
    send_item(OP_READ, 4095, 1, 1);           // far past the path
    write_reg(REG_END, 0);                    // start equals end
    send_item(OP_RUN, 0, 0, 0);
    write_reg(REG_END, 8);
    send_item(OP_WRITE, 8, 1, 0);             // walled goal
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_WRITE, 8, 0, 0);
    send_item(OP_WRITE, 0, 1, 0);             // walled start still expands
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0);
    write_reg(REG_END, 100);                  // goal outside the grid
    send_item(OP_RUN, 0, 0, 0);
    write_reg(REG_START, 9);                  // start outside the grid
    send_item(OP_RUN, 0, 0, 0);
    write_reg(REG_COLS, 0);                   // empty grid
    send_item(OP_RUN, 0, 0, 0);
    set_grid(127, 64, 0, 5);                  // too many cells
    send_item(OP_RUN, 0, 0, 0);
    set_grid(64, 64, 4095, 4094);             // full size, last corner
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_READ, 1, 0, 0);

    // random phases; one phase runs with no idling anywhere
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 5);
      random_phase(70);
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (rcvd != sent) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("grid_dijkstra_path_search verification clean");
    else
      $display("grid_dijkstra_path_search verification failed");
    $finish;
  end

endmodule
